// ----- rtl/core/i2r_pkg.sv -----
// shared types, constants and numeral tables for the roman numeral encoder
`default_nettype none

package i2r_pkg;

    localparam int VALUE_W  = 12;
    localparam int LETTER_W = 7;
    localparam int VALUE_MAX = 3999;

    // reciprocal multipliers for the decimal digit split
    localparam int THOU_RECIP  = 8389;
    localparam int THOU_SHIFT  = 23;
    localparam int THOU_WEIGHT = 1000;
    localparam int HUND_RECIP  = 41;
    localparam int HUND_SHIFT  = 12;
    localparam int HUND_WEIGHT = 100;
    localparam int TENS_RECIP  = 205;
    localparam int TENS_SHIFT  = 11;
    localparam int TENS_WEIGHT = 10;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [LETTER_W-1:0] CHAR_I = 7'h49;
    localparam logic [LETTER_W-1:0] CHAR_V = 7'h56;
    localparam logic [LETTER_W-1:0] CHAR_X = 7'h58;
    localparam logic [LETTER_W-1:0] CHAR_L = 7'h4C;
    localparam logic [LETTER_W-1:0] CHAR_C = 7'h43;
    localparam logic [LETTER_W-1:0] CHAR_D = 7'h44;
    localparam logic [LETTER_W-1:0] CHAR_M = 7'h4D;

    typedef struct packed {
        logic [1:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } i2r_digits_t;

    typedef enum logic [1:0] {
        PLACE_THOU,
        PLACE_HUND,
        PLACE_TENS,
        PLACE_ONES
    } i2r_place_t;

    typedef enum logic [1:0] {
        SYM_ONE,
        SYM_FIVE,
        SYM_TEN
    } i2r_sym_t;

    // characters in the numeral of one decimal digit
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] len;
        case (d)
            4'd1:    len = 3'd1;
            4'd2:    len = 3'd2;
            4'd3:    len = 3'd3;
            4'd4:    len = 3'd2;
            4'd5:    len = 3'd1;
            4'd6:    len = 3'd2;
            4'd7:    len = 3'd3;
            4'd8:    len = 3'd4;
            4'd9:    len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic i2r_sym_t digit_sym(input logic [3:0] d, input logic [1:0] pos);
        i2r_sym_t sym;
        case (d)
            4'd4:    sym = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
            4'd5,
            4'd6,
            4'd7,
            4'd8:    sym = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
            4'd9:    sym = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
            default: sym = SYM_ONE;
        endcase
        return sym;
    endfunction

    function automatic logic [LETTER_W-1:0] numeral_letter(input i2r_place_t place,
                                                           input i2r_sym_t sym);
        logic [LETTER_W-1:0] ch;
        case (place)
            PLACE_HUND: ch = (sym == SYM_ONE) ? CHAR_C : (sym == SYM_FIVE) ? CHAR_D : CHAR_M;
            PLACE_TENS: ch = (sym == SYM_ONE) ? CHAR_X : (sym == SYM_FIVE) ? CHAR_L : CHAR_C;
            PLACE_ONES: ch = (sym == SYM_ONE) ? CHAR_I : (sym == SYM_FIVE) ? CHAR_V : CHAR_X;
            default:    ch = CHAR_M;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/i2r_front.sv -----
// input side: saturates the value and splits it into decimal digits
`default_nettype none

module i2r_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [i2r_pkg::VALUE_W-1:0]   value,
    output logic                          push,
    output i2r_pkg::i2r_digits_t          push_data,
    input  logic                          full
);
    import i2r_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_THOU,
        F_HUND,
        F_TENS
    } state_t;

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   rest_reg, rest_next;
    logic [1:0]           thou_reg, thou_next;
    logic [3:0]           hund_reg, hund_next;

    logic [VALUE_W-1:0]   value_sat;
    logic [25:0]          thou_prod;
    logic [15:0]          hund_prod;
    logic [14:0]          tens_prod;
    logic [1:0]           thou_q;
    logic [3:0]           hund_q;
    logic [3:0]           tens_q;
    logic [3:0]           ones_q;

    assign value_sat = (value > VALUE_W'(VALUE_MAX)) ? VALUE_W'(VALUE_MAX) : value;

    assign thou_prod = 26'(rest_reg) * 26'(THOU_RECIP);
    assign hund_prod = 16'(rest_reg[9:0]) * 16'(HUND_RECIP);
    assign tens_prod = 15'(rest_reg[6:0]) * 15'(TENS_RECIP);

    assign thou_q = thou_prod[THOU_SHIFT +: 2];
    assign hund_q = hund_prod[HUND_SHIFT +: 4];
    assign tens_q = tens_prod[TENS_SHIFT +: 4];
    assign ones_q = 4'(rest_reg - VALUE_W'(tens_q) * VALUE_W'(TENS_WEIGHT));

    assign in_stall  = (state_reg != F_IDLE);
    assign push      = (state_reg == F_TENS) && !full;
    assign push_data = '{thou: thou_reg, hund: hund_reg, tens: tens_q, ones: ones_q};

    always_comb
    begin
        state_next = state_reg;
        rest_next  = rest_reg;
        thou_next  = thou_reg;
        hund_next  = hund_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    rest_next  = value_sat;
                    state_next = F_THOU;
                end
            end
            F_THOU:
            begin
                thou_next  = thou_q;
                rest_next  = rest_reg - VALUE_W'(thou_q) * VALUE_W'(THOU_WEIGHT);
                state_next = F_HUND;
            end
            F_HUND:
            begin
                hund_next  = hund_q;
                rest_next  = rest_reg - VALUE_W'(hund_q) * VALUE_W'(HUND_WEIGHT);
                state_next = F_TENS;
            end
            F_TENS:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            rest_reg  <= '0;
            thou_reg  <= '0;
            hund_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rest_reg  <= rest_next;
            thou_reg  <= thou_next;
            hund_reg  <= hund_next;
        end
    end

    // digit split must land in decimal range
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_TENS) |-> (hund_reg <= 4'd9) && (tens_q <= 4'd9) && (ones_q <= 4'd9))
        else $error("front digit split out of range");

endmodule

`default_nettype wire

// ----- rtl/core/i2r_fifo.sv -----
// short queue of digit sets between front and back
`default_nettype none

module i2r_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  i2r_pkg::i2r_digits_t  wr_data,
    output logic                  full,
    input  logic                  pop,
    output i2r_pkg::i2r_digits_t  rd_data,
    output logic                  empty
);
    import i2r_pkg::*;

    i2r_digits_t            entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full) && !(pop && empty))
        else $error("queue overflow or underflow");

endmodule

`default_nettype wire

// ----- rtl/core/i2r_back.sv -----
// output side: walks the digits and emits one numeral character per transfer
`default_nettype none

module i2r_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  i2r_pkg::i2r_digits_t                 rd_data,
    input  logic                                 empty,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [i2r_pkg::LETTER_W-1:0]         letter,
    output logic                                 last
);
    import i2r_pkg::*;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } state_t;

    state_t                 state_reg, state_next;
    i2r_digits_t            digits_reg, digits_next;
    i2r_place_t             place_reg, place_next;
    logic [1:0]             pos_reg, pos_next;
    logic                   out_valid_reg, out_valid_next;
    logic [LETTER_W-1:0]    letter_reg, letter_next;
    logic                   last_reg, last_next;

    logic [3:0]             cur_digit;
    logic [2:0]             cur_len;
    logic                   lower_zero;
    logic                   out_free;
    logic                   emit;
    logic                   skip;
    logic                   char_end;
    logic                   emit_last;

    always_comb
    begin
        case (place_reg)
            PLACE_THOU:
            begin
                cur_digit  = {2'b00, digits_reg.thou};
                lower_zero = (digits_reg.hund == '0) && (digits_reg.tens == '0)
                             && (digits_reg.ones == '0);
            end
            PLACE_HUND:
            begin
                cur_digit  = digits_reg.hund;
                lower_zero = (digits_reg.tens == '0) && (digits_reg.ones == '0);
            end
            PLACE_TENS:
            begin
                cur_digit  = digits_reg.tens;
                lower_zero = (digits_reg.ones == '0);
            end
            default:
            begin
                cur_digit  = digits_reg.ones;
                lower_zero = 1'b1;
            end
        endcase
    end

    assign cur_len   = digit_len(cur_digit);
    assign out_free  = !out_valid_reg || !out_stall;
    assign skip      = (state_reg == B_RUN) && (cur_len == '0);
    assign emit      = (state_reg == B_RUN) && (cur_len != '0) && out_free;
    assign char_end  = ({1'b0, pos_reg} == cur_len - 3'd1);
    assign emit_last = char_end && lower_zero;
    assign pop       = (state_reg == B_IDLE) && !empty;

    assign out_valid = out_valid_reg;
    assign letter    = letter_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        digits_next    = digits_reg;
        place_next     = place_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        letter_next    = letter_reg;
        last_next      = last_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    digits_next = rd_data;
                    place_next  = PLACE_THOU;
                    pos_next    = '0;
                    state_next  = B_RUN;
                end
            end
            B_RUN:
            begin
                if (skip)
                begin
                    // zero digit contributes no characters
                    if (place_reg == PLACE_ONES)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        place_next = i2r_place_t'(place_reg + 2'd1);
                    end
                end
                else if (emit)
                begin
                    if (emit_last)
                    begin
                        state_next = B_IDLE;
                    end
                    else if (char_end)
                    begin
                        pos_next   = '0;
                        place_next = i2r_place_t'(place_reg + 2'd1);
                    end
                    else
                    begin
                        pos_next = pos_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            letter_next    = numeral_letter(place_reg, digit_sym(cur_digit, pos_reg));
            last_next      = emit_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            digits_reg    <= '0;
            place_reg     <= PLACE_THOU;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            letter_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            digits_reg    <= digits_next;
            place_reg     <= place_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            letter_reg    <= letter_next;
            last_reg      <= last_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !emit_last) |=> (state_reg == B_RUN) && out_valid_reg && !last_reg)
        else $error("back stopped before final character");

    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> (state_reg == B_IDLE) && out_valid_reg && last_reg)
        else $error("final character not marked or back still running");

endmodule

`default_nettype wire

// ----- rtl/core/integer_to_roman_encoder.sv -----
// top level of the integer to roman numeral encoder
//
// Takes one 12-bit unsigned value per input transfer (values above 3999 are
// treated as 3999) and sends its subtractive roman numeral as ASCII
// characters, one per output transfer, most significant first, with last set
// on the final character; a value of zero sends nothing. The front end splits
// each value into decimal digits through its thousands, hundreds and tens
// states, and hands the digits to the back end through a two-entry queue. The
// back end sends at most one character per cycle: it loads a value from the
// queue only when idle, then spends a step on each character and on each zero
// digit ahead of its final character; 3888 gives the longest numeral, with 15
// characters. A character waiting under stall holds the back end, while the
// queue lets the front end go on splitting values until the queue is full.
`default_nettype none

module integer_to_roman_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [i2r_pkg::VALUE_W-1:0]         value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [i2r_pkg::LETTER_W-1:0]        letter,
    output logic                                last
);
    import i2r_pkg::*;

    logic         push;
    logic         pop;
    logic         full;
    logic         empty;
    i2r_digits_t  push_data;
    i2r_digits_t  rd_data;

    i2r_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    i2r_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .full    (full),
        .pop     (pop),
        .rd_data (rd_data),
        .empty   (empty)
    );

    i2r_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_data   (rd_data),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .letter    (letter),
        .last      (last)
    );

endmodule

`default_nettype wire
